@@ rtl/rdcu_pkg.sv @@
// Shared widths, register reset values, register codes and coefficient multiply helpers.
package rdcu_pkg;

  localparam int CW = 40;            // Q0.40 coefficient width
  localparam int TW = 32;            // Q16.16 time step width
  localparam int QW = 32;            // Q4.28 concentration width
  localparam int SW = 35;            // Q7.28 neighbor sum width
  localparam int LW = 37;            // Laplacian width
  localparam int OW = 34;            // one minus u width
  localparam int XW = 39;            // operand width into a coefficient multiply
  localparam int HW = CW / 2;        // coefficient half width
  localparam int PW = XW + HW + 1;   // partial product width
  localparam int DW = 41;            // derivative width
  localparam int EW = DW + HW / 2 + 1 + 6; // time step partial product width (58)
  localparam int RW = 60;            // width of the new value before saturation
  localparam int IN_W = 136;
  localparam int OUT_W = 64;
  localparam int IDX_W = 3;

  localparam logic signed [OW-1:0] ONE_Q28 = 34'sh0_1000_0000;

  localparam logic [CW-1:0] REACTION_RESET = 40'd1221679586;
  localparam logic [CW-1:0] FEED_RESET     = 40'd12725829;
  localparam logic [CW-1:0] KILL_RESET     = 40'd76354974;
  localparam logic [CW-1:0] U_DIFF_RESET   = 40'd252887674;
  localparam logic [CW-1:0] V_DIFF_RESET   = 40'd134140419;
  localparam logic [TW-1:0] STEP_RESET     = 32'd0;

  typedef enum logic [IDX_W-1:0] {
    CFG_REACTION  = 3'd0,
    CFG_FEED      = 3'd1,
    CFG_KILL      = 3'd2,
    CFG_U_DIFF    = 3'd3,
    CFG_V_DIFF    = 3'd4,
    CFG_TIME_STEP = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [CW-1:0] reaction;
    logic [CW-1:0] feed;
    logic [CW-1:0] kill;
    logic [CW-1:0] u_diff;
    logic [CW-1:0] v_diff;
    logic [TW-1:0] time_step;
  } coef_t;

  typedef struct packed {
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
  } pp_t;

  // Two half-width products of x by a Q0.40 coefficient.
  function automatic pp_t coef_split(input logic signed [XW-1:0] x,
                                     input logic [CW-1:0] c);
    pp_t p;
    logic signed [HW:0] ch;
    logic signed [HW:0] cl;
    ch = {1'b0, c[CW-1:HW]};
    cl = {1'b0, c[HW-1:0]};
    p.hi = x * ch;
    p.lo = x * cl;
    return p;
  endfunction

  // floor(x * c / 2^40) from the two partial products.
  function automatic logic signed [XW-1:0] coef_join(input pp_t p);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    logic signed [PW+HW-1:0] t;
    hi = p.hi;
    lo = p.lo;
    t = hi;
    t = (t <<< HW) + lo;
    return t[XW+CW-1:CW];
  endfunction

endpackage

@@ rtl/rdcu_datapath.sv @@
// Eight-stage arithmetic pipeline for one reaction-diffusion cell update.
module rdcu_datapath
  import rdcu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ce,
  input  logic                 in_valid,
  input  logic signed [QW-1:0] in_u,
  input  logic signed [QW-1:0] in_v,
  input  logic signed [SW-1:0] in_nu,
  input  logic signed [SW-1:0] in_nv,
  input  coef_t                coef,
  output logic                 out_valid,
  output logic [QW-1:0]        out_u,
  output logic [QW-1:0]        out_v,
  output logic                 out_clip
);

  logic [8:1] vld;

  // Stage 1: Laplacians, one minus u, u times v.
  logic signed [QW-1:0] u1, v1;
  logic signed [LW-1:0] lapu1, lapv1;
  logic signed [OW-1:0] omu1;
  logic signed [2*QW-1:0] uvp1;
  logic signed [LW-1:0] nu_x, nv_x, u_x, v_x, lapu_c, lapv_c;
  logic signed [OW-1:0] u_o, omu_c;
  logic signed [2*QW-1:0] uvp_c;

  always_comb begin
    nu_x = in_nu;
    nv_x = in_nv;
    u_x = in_u;
    v_x = in_v;
    lapu_c = nu_x - (u_x <<< 2) - (u_x <<< 1);
    lapv_c = nv_x - (v_x <<< 2) - (v_x <<< 1);
    u_o = in_u;
    omu_c = ONE_Q28 - u_o;
    uvp_c = in_u * in_v;
  end

  // Stage 2: uv times the halves of v, and the linear coefficient products.
  logic signed [QW-1:0] u2, v2;
  logic signed [52:0] uvh2, uvl2;
  pp_t feed_pp2, kill_pp2, lu_pp2, lv_pp2;
  logic signed [35:0] uv_c;
  logic signed [15:0] vh_c;
  logic signed [16:0] vl_c;
  logic signed [52:0] uvh_c, uvl_c;
  logic signed [XW-1:0] omu_x, v1_x, lapu_x, lapv_x;

  always_comb begin
    uv_c = uvp1[63:28];
    vh_c = v1[31:16];
    vl_c = {1'b0, v1[15:0]};
    uvh_c = uv_c * vh_c;
    uvl_c = uv_c * vl_c;
    omu_x = omu1;
    v1_x = v1;
    lapu_x = lapu1;
    lapv_x = lapv1;
  end

  // Stage 3: u*v*v and the linear terms.
  logic signed [QW-1:0] u3, v3;
  logic signed [XW-1:0] uvv3, feed3, kill3, lu3, lv3;
  logic signed [67:0] uvv_t;

  always_comb begin
    uvv_t = uvh2;
    uvv_t = (uvv_t <<< 16) + uvl2;
  end

  // Stage 4: reaction coefficient partial products.
  logic signed [QW-1:0] u4, v4;
  logic signed [XW-1:0] feed4, kill4, lu4, lv4;
  pp_t react_pp4;

  // Stage 5: reaction term.
  logic signed [QW-1:0] u5, v5;
  logic signed [XW-1:0] feed5, kill5, lu5, lv5, react5;

  // Stage 6: derivatives.
  logic signed [QW-1:0] u6, v6;
  logic signed [DW-1:0] du6, dv6;
  logic signed [DW-1:0] r_x, f_x, k_x, lu_x, lv_x;

  always_comb begin
    r_x = react5;
    f_x = feed5;
    k_x = kill5;
    lu_x = lu5;
    lv_x = lv5;
  end

  // Stage 7: time step partial products.
  logic signed [QW-1:0] u7, v7;
  logic signed [57:0] duh7, dul7, dvh7, dvl7;
  logic signed [16:0] th_c, tl_c;

  always_comb begin
    th_c = {1'b0, coef.time_step[31:16]};
    tl_c = {1'b0, coef.time_step[15:0]};
  end

  // Stage 8: new values with saturation.
  logic signed [RW-1:0] ru, rv, ulo, vlo;
  logic [QW-1:0] un_c, vn_c;
  logic u_sat, v_sat;

  always_comb begin
    ru = u7;
    rv = v7;
    ulo = dul7;
    vlo = dvl7;
    ru = ru + duh7 + (ulo >>> 16);
    rv = rv + dvh7 + (vlo >>> 16);
    // In range exactly when every bit above bit 31 copies the sign.
    u_sat = !((&ru[RW-1:QW-1]) || !(|ru[RW-1:QW-1]));
    v_sat = !((&rv[RW-1:QW-1]) || !(|rv[RW-1:QW-1]));
    if (u_sat) begin
      un_c = ru[RW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      un_c = ru[QW-1:0];
    end
    if (v_sat) begin
      vn_c = rv[RW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      vn_c = rv[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[7:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      u1 <= in_u;
      v1 <= in_v;
      lapu1 <= lapu_c;
      lapv1 <= lapv_c;
      omu1 <= omu_c;
      uvp1 <= uvp_c;

      u2 <= u1;
      v2 <= v1;
      uvh2 <= uvh_c;
      uvl2 <= uvl_c;
      feed_pp2 <= coef_split(omu_x, coef.feed);
      kill_pp2 <= coef_split(v1_x, coef.kill);
      lu_pp2 <= coef_split(lapu_x, coef.u_diff);
      lv_pp2 <= coef_split(lapv_x, coef.v_diff);

      u3 <= u2;
      v3 <= v2;
      uvv3 <= uvv_t[XW+27:28];
      feed3 <= coef_join(feed_pp2);
      kill3 <= coef_join(kill_pp2);
      lu3 <= coef_join(lu_pp2);
      lv3 <= coef_join(lv_pp2);

      u4 <= u3;
      v4 <= v3;
      feed4 <= feed3;
      kill4 <= kill3;
      lu4 <= lu3;
      lv4 <= lv3;
      react_pp4 <= coef_split(uvv3, coef.reaction);

      u5 <= u4;
      v5 <= v4;
      feed5 <= feed4;
      kill5 <= kill4;
      lu5 <= lu4;
      lv5 <= lv4;
      react5 <= coef_join(react_pp4);

      u6 <= u5;
      v6 <= v5;
      du6 <= f_x + lu_x - r_x;
      dv6 <= r_x - k_x + lv_x;

      u7 <= u6;
      v7 <= v6;
      duh7 <= du6 * th_c;
      dul7 <= du6 * tl_c;
      dvh7 <= dv6 * th_c;
      dvl7 <= dv6 * tl_c;

      out_u <= un_c;
      out_v <= vn_c;
      out_clip <= u_sat | v_sat;
    end
  end

  assign out_valid = vld[8];

endmodule

@@ rtl/reaction_diffusion_cell_update_top.sv @@
// Top level of the reaction-diffusion cell update: register file, stream ports, pipeline.
//
//  channel  | direction | handshake                  | content
//  ---------+-----------+----------------------------+-------------------------------------
//  s_       | in        | s_tvalid / s_tready        | one cell: centers and neighbor sums
//  m_       | out       | m_tvalid / m_tready        | new u and v, tuser = clipped
//  cfg_     | in        | cfg_valid / cfg_ready      | register index and write data
//
// One cell enters per clock while the output is not stalled; a result leaves through
// the eight register stages of the multiply chain (u*v, u*v*v, coefficient,
// time step, saturation). Reset clears the valid bits and loads the register defaults.
// A stall on the output freezes the whole pipeline, and s_tready drops only while the
// output holds a result that is not taken. Configuration writes are taken every cycle.
module reaction_diffusion_cell_update_top
  import rdcu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // u_center[31:0], v_center[63:32], u_neighbour_sum[98:64], v_neighbour_sum[133:99], zeros
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // u_next[31:0], v_next[63:32]
  output logic [OUT_W-1:0] m_tdata,
  // clipped[0]
  output logic             m_tuser,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CW-1:0]    cfg_data
);

  coef_t coef;
  logic ce;
  logic [QW-1:0] u_next, v_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.reaction  <= REACTION_RESET;
      coef.feed      <= FEED_RESET;
      coef.kill      <= KILL_RESET;
      coef.u_diff    <= U_DIFF_RESET;
      coef.v_diff    <= V_DIFF_RESET;
      coef.time_step <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_REACTION:  coef.reaction  <= cfg_data;
        CFG_FEED:      coef.feed      <= cfg_data;
        CFG_KILL:      coef.kill      <= cfg_data;
        CFG_U_DIFF:    coef.u_diff    <= cfg_data;
        CFG_V_DIFF:    coef.v_diff    <= cfg_data;
        CFG_TIME_STEP: coef.time_step <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is empty or being drained.
  assign ce = m_tready | ~m_tvalid;
  assign s_tready = ce;

  rdcu_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid & s_tready),
    .in_u      (s_tdata[31:0]),
    .in_v      (s_tdata[63:32]),
    .in_nu     (s_tdata[98:64]),
    .in_nv     (s_tdata[133:99]),
    .coef      (coef),
    .out_valid (m_tvalid),
    .out_u     (u_next),
    .out_v     (v_next),
    .out_clip  (m_tuser)
  );

  assign m_tdata = {v_next, u_next};

endmodule

@@ rtl/rdcu_checker.sv @@
// Port-level checks for the cell update block, bound to its top level.
module rdcu_checker
  import rdcu_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tuser,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  // A result waiting at the output holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  // No new beat is taken while a finished result is stuck at the output.
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // The register file takes a write in every cycle.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind reaction_diffusion_cell_update_top rdcu_checker u_rdcu_checker (.*);

@@ dv/testbench.sv @@
// Self-checking testbench for the reaction-diffusion cell update: directed table, random cells.
module testbench;
  import rdcu_pkg::*;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h1000_0000;
  localparam logic [31:0] Q_NEG1 = 32'hFFFF_FFFF;
  localparam logic [34:0] S_MAX = 35'h3_FFFF_FFFF;
  localparam logic [34:0] S_MIN = 35'h4_0000_0000;
  localparam logic [34:0] S_SIX = 35'h0_6000_0000;
  localparam logic [34:0] S_NEG1 = 35'h7_FFFF_FFFF;
  localparam logic signed [127:0] UNIT_Q28 = 128'sd268435456;
  localparam logic signed [127:0] Q28_TOP = 128'sd2147483647;
  localparam logic signed [127:0] Q28_BOTTOM = -128'sd2147483648;
  // Indexes past the register list; writes there must change nothing.
  localparam logic [IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] IDX_SPARE_B = 3'd7;
  localparam int DIR_N = 20;
  localparam int PHASES = 6;
  localparam int CELLS_PER_PHASE = 172;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 90;
  localparam int DRAIN_CYCLES = 20;

  typedef enum {SET_RESET, SET_MAX, SET_MID, SET_ZERO} coef_set_e;

  typedef struct packed {
    logic [34:0] v_nsum;
    logic [34:0] u_nsum;
    logic [31:0] v_center;
    logic [31:0] u_center;
  } cell_t;

  typedef struct packed {
    logic [31:0] u_next;
    logic [31:0] v_next;
    logic        clipped;
  } result_t;

  typedef struct {
    coef_set_e setting;
    cell_t     item;
    bit        typed;
    result_t   want;
  } row_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CW-1:0]    cfg_data;

  coef_t   regs_now;
  result_t pending_updates[$];
  row_t    dir_rows [DIR_N];
  int      mismatch_count;
  int      updates_seen;
  int      src_calm;

  reaction_diffusion_cell_update_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // floor(x * c / 2^40) for an unsigned Q0.40 coefficient.
  function automatic logic signed [127:0] scale_q40(input logic signed [127:0] x,
                                                    input logic [CW-1:0] c);
    logic signed [127:0] cs;
    cs = {88'd0, c};
    return (x * cs) >>> 40;
  endfunction

  // Bit 32 flags saturation, bits 31:0 hold the clamped Q4.28 value.
  function automatic logic [32:0] clamp_q28(input logic signed [127:0] x);
    if (x > Q28_TOP) return {1'b1, Q_MAX};
    if (x < Q28_BOTTOM) return {1'b1, Q_MIN};
    return {1'b0, x[31:0]};
  endfunction

  // Exact wide arithmetic; the floors match the split products of the hardware.
  function automatic result_t predict_update(input cell_t c, input coef_t k);
    logic signed [127:0] u, v, lap_u, lap_v, uvv, react, du, dv, dt;
    logic [32:0] cu, cv;
    result_t r;
    u = {{96{c.u_center[31]}}, c.u_center};
    v = {{96{c.v_center[31]}}, c.v_center};
    lap_u = {{93{c.u_nsum[34]}}, c.u_nsum} - u * 128'sd6;
    lap_v = {{93{c.v_nsum[34]}}, c.v_nsum} - v * 128'sd6;
    uvv = (((u * v) >>> 28) * v) >>> 28;
    react = scale_q40(uvv, k.reaction);
    du = scale_q40(UNIT_Q28 - u, k.feed) + scale_q40(lap_u, k.u_diff) - react;
    dv = react - scale_q40(v, k.kill) + scale_q40(lap_v, k.v_diff);
    dt = {96'd0, k.time_step};
    cu = clamp_q28(u + ((dt * du) >>> 16));
    cv = clamp_q28(v + ((dt * dv) >>> 16));
    r.u_next = cu[31:0];
    r.v_next = cv[31:0];
    r.clipped = cu[32] | cv[32];
    return r;
  endfunction

  function automatic row_t mk_row(input coef_set_e s, input logic [31:0] u, input logic [31:0] v,
                                  input logic [34:0] nu, input logic [34:0] nv, input bit typed,
                                  input logic [31:0] eu, input logic [31:0] ev, input logic ec);
    row_t r;
    r.setting = s;
    r.item = '{v_nsum: nv, u_nsum: nu, v_center: v, u_center: u};
    r.typed = typed;
    r.want = '{u_next: eu, v_next: ev, clipped: ec};
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] extreme_q32();
    case ($urandom_range(0, 5))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return Q_NEG1;
      4: return Q_ONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [34:0] extreme_s35();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return S_NEG1;
      4: return S_SIX;
      default: return w[34:0];
    endcase
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    logic [63:0] a, b;
    logic signed [39:0] sum_u, sum_v;
    int mode;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      // Concentrations in their usual range, neighbors close to the center.
      c.u_center = {4'd0, a[27:0]};
      c.v_center = {5'd0, a[58:32]};
      sum_u = 40'sd6 * $signed({8'd0, c.u_center}) + $signed({{14{b[25]}}, b[25:0]});
      sum_v = 40'sd6 * $signed({8'd0, c.v_center}) + $signed({{14{b[57]}}, b[57:32]});
      c.u_nsum = sum_u[34:0];
      c.v_nsum = sum_v[34:0];
    end else if (mode < 8) begin
      c.u_center = a[31:0];
      c.v_center = a[63:32];
      c.u_nsum = b[34:0];
      c.v_nsum = {b[63:35], a[5:0]};
    end else begin
      c.u_center = extreme_q32();
      c.v_center = extreme_q32();
      c.u_nsum = extreme_s35();
      c.v_nsum = extreme_s35();
    end
    return c;
  endfunction

  function automatic logic [CW-1:0] pick_coef(input bit is_step);
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return w[39:0];
      // Junk above the time step width must be dropped by the block.
      default: return is_step ? {w[39:32], 14'd0, w[17:0]} : {13'd0, w[26:0]};
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 40)
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endfunction

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_REACTION:  regs_now.reaction = data;
      CFG_FEED:      regs_now.feed = data;
      CFG_KILL:      regs_now.kill = data;
      CFG_U_DIFF:    regs_now.u_diff = data;
      CFG_V_DIFF:    regs_now.v_diff = data;
      CFG_TIME_STEP: regs_now.time_step = data[TW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_set(input coef_set_e s);
    logic [CW-1:0] r, f, k, du, dv, dt;
    case (s)
      SET_MAX: begin
        r = '1; f = '1; k = '1; du = '1; dv = '1; dt = '1;
      end
      SET_ZERO: begin
        r = '0; f = '0; k = '0; du = '0; dv = '0; dt = '1;
      end
      default: begin
        r = REACTION_RESET; f = FEED_RESET; k = KILL_RESET;
        du = U_DIFF_RESET; dv = V_DIFF_RESET;
        dt = (s == SET_MID) ? 40'h00_0001_0000 : 40'h0;
      end
    endcase
    cfg_write(CFG_REACTION, r);
    cfg_write(CFG_FEED, f);
    cfg_write(CFG_KILL, k);
    cfg_write(CFG_U_DIFF, du);
    cfg_write(CFG_V_DIFF, dv);
    cfg_write(CFG_TIME_STEP, dt);
    cfg_write(IDX_SPARE_A, '1);
    cfg_write(IDX_SPARE_B, 40'h5A_A5C3_3C96);
  endtask

  task automatic shuffle_regs();
    cfg_write(CFG_REACTION, pick_coef(1'b0));
    cfg_write(CFG_FEED, pick_coef(1'b0));
    cfg_write(CFG_KILL, pick_coef(1'b0));
    cfg_write(CFG_U_DIFF, pick_coef(1'b0));
    cfg_write(CFG_V_DIFF, pick_coef(1'b0));
    cfg_write(CFG_TIME_STEP, pick_coef(1'b1));
    if ($urandom_range(0, 1) == 0) cfg_write(IDX_SPARE_A, pick_coef(1'b0));
  endtask

  task automatic send_cell(input cell_t c, input bit typed, input result_t want);
    int gap;
    if (src_calm > 0) begin
      src_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) src_calm = $urandom_range(30, 80);
      gap = pick_gap();
    end
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, c.v_nsum, c.u_nsum, c.v_center, c.u_center};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_updates.push_back(typed ? want : predict_update(c, regs_now));
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    coef_set_e cur;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_REACTION;
    cfg_data <= '0;
    regs_now.reaction = REACTION_RESET;
    regs_now.feed = FEED_RESET;
    regs_now.kill = KILL_RESET;
    regs_now.u_diff = U_DIFF_RESET;
    regs_now.v_diff = V_DIFF_RESET;
    regs_now.time_step = STEP_RESET;
    src_calm = 0;
    dir_rows = '{
      // Zero time step after reset: the centers pass through untouched.
      mk_row(SET_RESET, 32'h0, 32'h0, 35'h0, 35'h0, 1, 32'h0, 32'h0, 1'b0),
      mk_row(SET_RESET, Q_MAX, Q_MAX, S_MAX, S_MAX, 1, Q_MAX, Q_MAX, 1'b0),
      mk_row(SET_RESET, Q_MIN, Q_MIN, S_MIN, S_MIN, 1, Q_MIN, Q_MIN, 1'b0),
      mk_row(SET_RESET, Q_MAX, Q_MIN, S_MIN, S_MAX, 1, Q_MAX, Q_MIN, 1'b0),
      mk_row(SET_RESET, Q_NEG1, 32'h1, S_NEG1, 35'h0, 1, Q_NEG1, 32'h1, 1'b0),
      mk_row(SET_RESET, Q_ONE, Q_ONE, S_SIX, S_SIX, 0, '0, '0, 1'b0),
      // Every coefficient and the time step at full scale: saturation both ways.
      mk_row(SET_MAX, Q_MAX, 32'h0, S_MAX, 35'h0, 1, Q_MAX, 32'h0, 1'b1),
      mk_row(SET_MAX, Q_MIN, 32'h0, S_MIN, 35'h0, 1, Q_MIN, 32'h0, 1'b1),
      mk_row(SET_MAX, 32'h0, Q_MAX, 35'h0, S_MAX, 1, Q_MAX, Q_MAX, 1'b1),
      mk_row(SET_MAX, Q_ONE, 32'h0, S_SIX, 35'h0, 1, Q_ONE, 32'h0, 1'b0),
      mk_row(SET_MAX, Q_MIN, Q_MIN, S_MIN, S_MIN, 0, '0, '0, 1'b0),
      mk_row(SET_MAX, Q_MAX, Q_MAX, S_MAX, S_MAX, 0, '0, '0, 1'b0),
      mk_row(SET_MAX, Q_NEG1, Q_NEG1, S_NEG1, S_NEG1, 0, '0, '0, 1'b0),
      // Default coefficients with a unit time step.
      mk_row(SET_MID, Q_ONE, 32'h0, S_SIX, 35'h0, 1, Q_ONE, 32'h0, 1'b0),
      mk_row(SET_MID, 32'h0800_0000, 32'h0400_0000, 35'h0_3000_0000, 35'h0_1800_0000,
             0, '0, '0, 1'b0),
      mk_row(SET_MID, 32'h0C00_0000, 32'h0200_0000, 35'h0_4000_0000, 35'h0_2000_0000,
             0, '0, '0, 1'b0),
      mk_row(SET_MID, Q_ONE, Q_ONE, S_SIX, S_SIX, 0, '0, '0, 1'b0),
      // Zero coefficients: no derivative however long the step.
      mk_row(SET_ZERO, Q_MAX, Q_MIN, S_MIN, S_MAX, 1, Q_MAX, Q_MIN, 1'b0),
      mk_row(SET_ZERO, Q_MIN, Q_MAX, S_MAX, S_MIN, 1, Q_MIN, Q_MAX, 1'b0),
      mk_row(SET_ZERO, 32'h1234_5678, 32'h9ABC_DEF0, 35'h5_5555_5555, 35'h2_AAAA_AAAA,
             1, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0)
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cur = SET_RESET;
    for (int i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].setting != cur) begin
        drain();
        load_set(dir_rows[i].setting);
        cur = dir_rows[i].setting;
      end
      send_cell(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == 0) load_set(SET_MID);
      else if (p == PHASES - 1) load_set(SET_MAX);
      else shuffle_regs();
      for (int n = 0; n < CELLS_PER_PHASE; n++) send_cell(random_cell(), 1'b0, '0);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("reaction_diffusion_cell_update_top test passed");
    end else begin
      $display("reaction_diffusion_cell_update_top test failed");
    end
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    int calm_left;
    bit held;
    stall_left = 0;
    calm_left = 0;
    held = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (!held && updates_seen >= HOLD_AT) begin
        // Long hold-off so the pipeline fills and the input side stalls.
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 59) == 0) calm_left = $urandom_range(30, 80);
        else stall_left = pick_gap();
      end
    end
  end

  initial begin : result_check
    result_t got, want;
    bit seen;
    mismatch_count = 0;
    updates_seen = 0;
    forever begin
      @(posedge clk);
      seen = !rst && m_tvalid && m_tready;
      got.u_next = m_tdata[31:0];
      got.v_next = m_tdata[63:32];
      got.clipped = m_tuser;
      if (seen) updates_seen++;
      // Compare at the falling edge so every beat accepted at this edge is queued.
      @(negedge clk);
      if (seen) begin
        if (pending_updates.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 40)
            $display("%0t: unexpected result beat, expected none, got u %h v %h clipped %b",
                     $time, got.u_next, got.v_next, got.clipped);
        end else begin
          want = pending_updates.pop_front();
          check_field("u_next", want.u_next, got.u_next);
          check_field("v_next", want.v_next, got.v_next);
          check_field("clipped", {31'd0, want.clipped}, {31'd0, got.clipped});
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("reaction_diffusion_cell_update_top test failed");
    $finish;
  end

endmodule
